// ===== rtl/nps_pkg.sv =====
// shared constants for the nand page state array
package nps_pkg;

  localparam int unsigned InDataWidth  = 56;
  localparam int unsigned OutDataWidth = 40;
  localparam int unsigned ProdWidth    = 17;

  localparam logic [2:0] CMD_READ    = 3'd0;
  localparam logic [2:0] CMD_PROGRAM = 3'd1;
  localparam logic [2:0] CMD_ERASE   = 3'd2;
  localparam logic [2:0] CMD_GET     = 3'd3;
  localparam logic [2:0] CMD_SET     = 3'd4;

  localparam logic [1:0] ST_CLEAN   = 2'd0;
  localparam logic [1:0] ST_VALID   = 2'd1;
  localparam logic [1:0] ST_INVALID = 2'd2;

  localparam logic [2:0] RC_OK               = 3'd0;
  localparam logic [2:0] RC_BAD_ADDR         = 3'd1;
  localparam logic [2:0] RC_NOT_CLEAN        = 3'd2;
  localparam logic [2:0] RC_READ_NONVALID    = 3'd3;
  localparam logic [2:0] RC_INVALID_TO_VALID = 3'd4;

  typedef struct packed {
    logic st_we;
    logic dat_we;
  } nps_wr_t;

endpackage

// ===== rtl/nps_store.sv =====
// page status and page data memories with one write and one registered read port
module nps_store #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12,
  parameter int unsigned DW    = 32
) (
  input  logic             clk_i,
  input  nps_pkg::nps_wr_t wr_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [1:0]       wr_status_i,
  input  logic [DW-1:0]    wr_data_i,
  input  logic             rd_en_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [1:0]       rd_status_o,
  output logic [DW-1:0]    rd_data_o
);
  import nps_pkg::*;

  logic [1:0]    status_mem [DEPTH];
  logic [DW-1:0] data_mem   [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_i.st_we) begin
      status_mem[wr_addr_i] <= wr_status_i;
    end
    if (wr_i.dat_we) begin
      data_mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_status_o <= status_mem[rd_addr_i];
      rd_data_o   <= data_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/nps_ctrl.sv =====
// command sequencer with shared address adder, walk counter and result register
module nps_ctrl #(
  parameter int unsigned NUM_BLOCKS  = 64,
  parameter int unsigned BLOCK_PAGES = 64,
  parameter int unsigned DW          = 32,
  parameter int unsigned AW          = 12
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [2:0]       cmd_i,
  input  logic [7:0]       block_index_i,
  input  logic [7:0]       page_index_i,
  input  logic [DW-1:0]    write_data_i,
  input  logic [1:0]       new_status_i,
  output nps_pkg::nps_wr_t wr_o,
  output logic [AW-1:0]    wr_addr_o,
  output logic [1:0]       wr_status_o,
  output logic [DW-1:0]    wr_data_o,
  output logic             rd_en_o,
  output logic [AW-1:0]    rd_addr_o,
  input  logic [1:0]       rd_status_i,
  input  logic [DW-1:0]    rd_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [31:0]      read_data_o,
  output logic [1:0]       page_status_o,
  output logic [2:0]       result_code_o
);
  import nps_pkg::*;

  localparam int unsigned PageCount = NUM_BLOCKS * BLOCK_PAGES;
  localparam logic [AW-1:0] ClearLast = AW'(PageCount - 1);
  localparam logic [AW-1:0] EraseLast = AW'(BLOCK_PAGES - 1);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_ERASE
  } state_e;

  state_e          state_q;
  logic [AW-1:0]   cnt_q;
  logic [AW-1:0]   base_q;
  logic [AW-1:0]   slot_q;
  logic [2:0]      cmd_q;
  logic            blk_ok_q;
  logic            pg_ok_q;
  logic [DW-1:0]   wdata_q;
  logic [1:0]      nstat_q;
  logic            out_valid_q;
  logic [31:0]     read_data_q;
  logic [1:0]      page_status_q;
  logic [2:0]      result_code_q;

  logic [ProdWidth-1:0] prod;
  logic [ProdWidth-1:0] op_a;
  logic [ProdWidth-1:0] op_b;
  logic [ProdWidth-1:0] sum;
  logic                 walk;
  logic                 walk_last;
  logic                 accept;
  logic                 out_free;
  logic                 res_load;
  logic                 blk_ok;
  logic                 pg_ok;
  logic                 addr_ok;
  logic [DW+31:0]       rd_ext;
  logic [1:0]           ns;

  nps_wr_t     ex_wr;
  logic [1:0]  ex_status;
  logic [DW-1:0] ex_data;
  logic [31:0] ex_rdata;
  logic [1:0]  ex_pstat;
  logic [2:0]  ex_code;
  logic        ex_erase;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign walk       = (state_q == S_CLEAR) || (state_q == S_ERASE);
  assign walk_last  = (state_q == S_CLEAR) ? (cnt_q == ClearLast) : (cnt_q == EraseLast);
  assign res_load   = out_free && (((state_q == S_EXEC) && !ex_erase) ||
                                   ((state_q == S_ERASE) && walk_last));

  assign blk_ok = {1'b0, block_index_i} < 9'(NUM_BLOCKS);
  assign pg_ok  = {1'b0, page_index_i} < 9'(BLOCK_PAGES);
  assign prod   = ProdWidth'(block_index_i) * ProdWidth'(BLOCK_PAGES);

  // shared slot adder: block base plus page offset
  assign op_a = walk ? ProdWidth'(base_q) : prod;
  assign op_b = walk ? ProdWidth'(cnt_q) : ProdWidth'(page_index_i);
  assign sum  = op_a + op_b;

  assign rd_en_o   = accept;
  assign rd_addr_o = sum[AW-1:0];

  assign addr_ok = blk_ok_q && pg_ok_q;
  assign rd_ext  = {32'b0, rd_data_i};
  assign ns      = (nstat_q > ST_INVALID) ? ST_INVALID : nstat_q;

  always_comb begin
    ex_wr     = '0;
    ex_status = rd_status_i;
    ex_data   = wdata_q;
    ex_rdata  = '0;
    ex_pstat  = ST_CLEAN;
    ex_code   = RC_OK;
    ex_erase  = 1'b0;
    unique case (cmd_q)
      CMD_READ: begin
        if (!addr_ok) begin
          ex_code = RC_BAD_ADDR;
        end else begin
          if (rd_status_i != ST_VALID) begin
            ex_code = RC_READ_NONVALID;
          end
          if (rd_status_i != ST_CLEAN) begin
            ex_rdata = rd_ext[31:0];
          end
        end
      end
      CMD_PROGRAM: begin
        if (!addr_ok) begin
          ex_code = RC_BAD_ADDR;
        end else if (rd_status_i != ST_CLEAN) begin
          ex_code = RC_NOT_CLEAN;
        end else begin
          ex_wr.st_we  = 1'b1;
          ex_wr.dat_we = 1'b1;
          ex_status    = ST_VALID;
        end
      end
      CMD_ERASE: begin
        if (!blk_ok_q) begin
          ex_code = RC_BAD_ADDR;
        end else begin
          ex_erase = 1'b1;
        end
      end
      CMD_GET: begin
        if (!addr_ok) begin
          ex_code  = RC_BAD_ADDR;
          ex_pstat = ST_INVALID;
        end else begin
          ex_pstat = rd_status_i;
        end
      end
      CMD_SET: begin
        if (!addr_ok) begin
          ex_code = RC_BAD_ADDR;
        end else begin
          if (rd_status_i == ST_INVALID && ns == ST_VALID) begin
            ex_code = RC_INVALID_TO_VALID;
          end
          ex_wr.st_we = 1'b1;
          ex_status   = ns;
        end
      end
      default: begin
        ex_code = RC_OK;
      end
    endcase
  end

  // memory write port
  always_comb begin
    wr_o        = '0;
    wr_addr_o   = slot_q;
    wr_status_o = ex_status;
    wr_data_o   = ex_data;
    unique case (state_q)
      S_CLEAR: begin
        wr_o.st_we  = 1'b1;
        wr_addr_o   = sum[AW-1:0];
        wr_status_o = ST_CLEAN;
      end
      S_ERASE: begin
        wr_o.st_we  = 1'b1;
        wr_o.dat_we = 1'b1;
        wr_addr_o   = sum[AW-1:0];
        wr_status_o = ST_CLEAN;
        wr_data_o   = '0;
      end
      S_EXEC: begin
        if (out_free) begin
          wr_o = ex_wr;
        end
      end
      default: begin
        wr_o = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_CLEAR;
      cnt_q         <= '0;
      base_q        <= '0;
      out_valid_q   <= 1'b0;
      slot_q        <= '0;
      cmd_q         <= CMD_READ;
      blk_ok_q      <= 1'b0;
      pg_ok_q       <= 1'b0;
      wdata_q       <= '0;
      nstat_q       <= ST_CLEAN;
      read_data_q   <= '0;
      page_status_q <= ST_CLEAN;
      result_code_q <= RC_OK;
    end else begin
      if (res_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_CLEAR: begin
          if (walk_last) begin
            cnt_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (accept) begin
            cmd_q    <= cmd_i;
            blk_ok_q <= blk_ok;
            pg_ok_q  <= pg_ok;
            wdata_q  <= write_data_i;
            nstat_q  <= new_status_i;
            slot_q   <= sum[AW-1:0];
            base_q   <= prod[AW-1:0];
            state_q  <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (ex_erase) begin
            cnt_q   <= '0;
            state_q <= S_ERASE;
          end else if (out_free) begin
            read_data_q   <= ex_rdata;
            page_status_q <= ex_pstat;
            result_code_q <= ex_code;
            state_q       <= S_IDLE;
          end
        end
        S_ERASE: begin
          if (!walk_last) begin
            cnt_q <= cnt_q + 1'b1;
          end else if (out_free) begin
            read_data_q   <= '0;
            page_status_q <= ST_CLEAN;
            result_code_q <= RC_OK;
            cnt_q         <= '0;
            state_q       <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o   = out_valid_q;
  assign read_data_o   = read_data_q;
  assign page_status_o = page_status_q;
  assign result_code_o = result_code_q;

endmodule

// ===== rtl/nand_page_state_array.sv =====
// top level of the nand page state array
//
// one request on the slave stream carries a command, a block and page address,
// a data word and a status; each request gives exactly one result on the master
// stream with the read data, the page status and a result code.
// read, program, get status and set status take the request and read the page
// in the idle state, then check, write back and register the result in the exec state.
// erase block walks every page of the block: the walk counter clears one page
// per cycle through the single memory write port.
// a new request is taken only after the previous one has left the sequencer.
// the result register frees the sequencer while a result waits; when the
// receiver stalls with a result still held, the next result waits in the
// sequencer and no further request is taken.
// after reset the status memory is cleared one page per cycle, with
// s_axis_tready_o low until the last page is cleared.
module nand_page_state_array #(
  parameter int unsigned NUM_BLOCKS  = 64,
  parameter int unsigned BLOCK_PAGES = 64,
  parameter int unsigned DATA_WIDTH  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  // cmd[2:0], block_index[10:3], page_index[18:11], write_data[50:19], new_status[52:51]
  input  logic [nps_pkg::InDataWidth-1:0]     s_axis_tdata_i,
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  // read_data[31:0], page_status[33:32], result_code[36:34]
  output logic [nps_pkg::OutDataWidth-1:0]    m_axis_tdata_o
);
  import nps_pkg::*;

  localparam int unsigned PageCount = NUM_BLOCKS * BLOCK_PAGES;
  localparam int unsigned AW = (PageCount > 1) ? $clog2(PageCount) : 1;

  logic [DATA_WIDTH+31:0] wdata_ext;
  logic [DATA_WIDTH-1:0]  write_data;
  nps_wr_t                wr;
  logic [AW-1:0]          wr_addr;
  logic [1:0]             wr_status;
  logic [DATA_WIDTH-1:0]  wr_data;
  logic                   rd_en;
  logic [AW-1:0]          rd_addr;
  logic [1:0]             rd_status;
  logic [DATA_WIDTH-1:0]  rd_data;
  logic [31:0]            read_data;
  logic [1:0]             page_status;
  logic [2:0]             result_code;

  assign wdata_ext  = {{DATA_WIDTH{1'b0}}, s_axis_tdata_i[50:19]};
  assign write_data = wdata_ext[DATA_WIDTH-1:0];

  nps_ctrl #(
    .NUM_BLOCKS  (NUM_BLOCKS),
    .BLOCK_PAGES (BLOCK_PAGES),
    .DW          (DATA_WIDTH),
    .AW          (AW)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .cmd_i         (s_axis_tdata_i[2:0]),
    .block_index_i (s_axis_tdata_i[10:3]),
    .page_index_i  (s_axis_tdata_i[18:11]),
    .write_data_i  (write_data),
    .new_status_i  (s_axis_tdata_i[52:51]),
    .wr_o          (wr),
    .wr_addr_o     (wr_addr),
    .wr_status_o   (wr_status),
    .wr_data_o     (wr_data),
    .rd_en_o       (rd_en),
    .rd_addr_o     (rd_addr),
    .rd_status_i   (rd_status),
    .rd_data_i     (rd_data),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .read_data_o   (read_data),
    .page_status_o (page_status),
    .result_code_o (result_code)
  );

  nps_store #(
    .DEPTH (PageCount),
    .AW    (AW),
    .DW    (DATA_WIDTH)
  ) u_store (
    .clk_i       (clk_i),
    .wr_i        (wr),
    .wr_addr_i   (wr_addr),
    .wr_status_i (wr_status),
    .wr_data_i   (wr_data),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_status_o (rd_status),
    .rd_data_o   (rd_data)
  );

  assign m_axis_tdata_o = {3'b000, result_code, page_status, read_data};

endmodule

// ===== rtl/nps_checker.sv =====
// port checker for the nand page state array and its bind
module nps_checker (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             s_axis_tvalid_i,
  input logic                             s_axis_tready_o,
  input logic [nps_pkg::InDataWidth-1:0]  s_axis_tdata_i,
  input logic                             m_axis_tvalid_o,
  input logic                             m_axis_tready_i,
  input logic [nps_pkg::OutDataWidth-1:0] m_axis_tdata_o
);
  import nps_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // one request at a time
  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("request taken while busy");

  // bad address gives zero data
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[36:34] == RC_BAD_ADDR |-> m_axis_tdata_o[31:0] == 32'd0)
    else $error("data on bad address");

  // status and code in range
  a_ranges: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[33:32] != 2'd3 && m_axis_tdata_o[36:34] <= RC_INVALID_TO_VALID)
    else $error("result field out of range");

endmodule

bind nand_page_state_array nps_checker u_nps_checker (.*);

// ===== verif/nand_page_state_array_tb.sv =====
// testbench for the nand page state array: directed and random requests checked by an in-bench predictor
`timescale 1ns / 100ps

module nand_page_state_array_tb;
  import nps_pkg::*;

  localparam int unsigned NUM_BLOCKS      = 64;
  localparam int unsigned BLOCK_PAGES     = 64;
  localparam int unsigned DATA_WIDTH      = 32;
  localparam int unsigned PAGE_COUNT      = NUM_BLOCKS * BLOCK_PAGES;
  localparam int unsigned SLOT_W          = $clog2(PAGE_COUNT);
  localparam int unsigned WATCHDOG_LIMIT  = 20000;
  localparam int unsigned DRAIN_CYCLES    = BLOCK_PAGES + 16;
  localparam int unsigned MAX_PRINTS      = 50;

  typedef struct packed {
    logic [2:0]  code;
    logic [1:0]  pstat;
    logic [31:0] rdata;
  } page_rsp_t;

  logic                    clk_i;
  logic                    rst_ni = 1'b0;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  logic [OutDataWidth-1:0] m_tdata;

  logic [1:0]  status_mem [PAGE_COUNT];
  logic [31:0] data_mem [PAGE_COUNT];
  bit          data_known [PAGE_COUNT];
  page_rsp_t   page_rsp_q [$];

  int unsigned src_idle_pct = 0;
  int unsigned snk_stall_pct = 0;
  int unsigned mismatch_cnt = 0;
  int unsigned quiet_cycles = 0;

  nand_page_state_array #(
    .NUM_BLOCKS     (NUM_BLOCKS),
    .BLOCK_PAGES    (BLOCK_PAGES),
    .DATA_WIDTH     (DATA_WIDTH)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  function automatic page_rsp_t apply_page_cmd(input logic [2:0] cmd, input logic [7:0] blk,
                                               input logic [7:0] pg, input logic [31:0] wdata,
                                               input logic [1:0] nstat);
    page_rsp_t         rsp;
    logic              addr_ok;
    logic [SLOT_W-1:0] slot;
    logic [1:0]        ns;
    rsp = '0;
    addr_ok = (blk < NUM_BLOCKS) && (pg < BLOCK_PAGES);
    slot = addr_ok ? SLOT_W'(blk * BLOCK_PAGES + pg) : '0;
    case (cmd)
      CMD_READ: begin
        if (!addr_ok) begin
          rsp.code = RC_BAD_ADDR;
        end else begin
          if (status_mem[slot] != ST_VALID) rsp.code = RC_READ_NONVALID;
          if (status_mem[slot] != ST_CLEAN) rsp.rdata = data_mem[slot];
        end
      end
      CMD_PROGRAM: begin
        if (!addr_ok) begin
          rsp.code = RC_BAD_ADDR;
        end else if (status_mem[slot] != ST_CLEAN) begin
          rsp.code = RC_NOT_CLEAN;
        end else begin
          data_mem[slot] = wdata;
          data_known[slot] = 1'b1;
          status_mem[slot] = ST_VALID;
        end
      end
      CMD_ERASE: begin
        if (blk >= NUM_BLOCKS) begin
          rsp.code = RC_BAD_ADDR;
        end else begin
          for (int unsigned p = 0; p < BLOCK_PAGES; p++) begin
            status_mem[SLOT_W'(blk * BLOCK_PAGES + p)] = ST_CLEAN;
            data_mem[SLOT_W'(blk * BLOCK_PAGES + p)] = '0;
            data_known[SLOT_W'(blk * BLOCK_PAGES + p)] = 1'b1;
          end
        end
      end
      CMD_GET: begin
        if (!addr_ok) begin
          rsp.code = RC_BAD_ADDR;
          rsp.pstat = ST_INVALID;
        end else begin
          rsp.pstat = status_mem[slot];
        end
      end
      CMD_SET: begin
        if (!addr_ok) begin
          rsp.code = RC_BAD_ADDR;
        end else begin
          ns = (nstat > ST_INVALID) ? ST_INVALID : nstat;
          if (status_mem[slot] == ST_INVALID && ns == ST_VALID) rsp.code = RC_INVALID_TO_VALID;
          status_mem[slot] = ns;
        end
      end
      default: ;
    endcase
    return rsp;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    if (mismatch_cnt < MAX_PRINTS) begin
      $display("%0t: %s: expected %0h got %0h", $time, what, exp_v, got_v);
    end
    mismatch_cnt++;
  endtask

  task automatic send_request(input logic [2:0] cmd, input logic [7:0] blk, input logic [7:0] pg,
                              input logic [31:0] wdata, input logic [1:0] nstat);
    logic [SLOT_W-1:0] slot;
    logic [2:0]        op;
    op = cmd;
    slot = SLOT_W'(blk * BLOCK_PAGES + pg);
    // never read data of a page that was only given a status since reset
    if (op == CMD_READ && blk < NUM_BLOCKS && pg < BLOCK_PAGES) begin
      if (status_mem[slot] != ST_CLEAN && !data_known[slot]) op = CMD_GET;
    end
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {3'b000, nstat, wdata, pg, blk, op};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    page_rsp_q.push_back(apply_page_cmd(op, blk, pg, wdata, nstat));
  endtask

  task automatic wait_for_drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (page_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    m_tready <= ($urandom_range(99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin : check_results
    page_rsp_t got;
    page_rsp_t exp_rsp;
    if (rst_ni && m_tvalid && m_tready) begin
      got = m_tdata[36:0];
      if (page_rsp_q.size() == 0) begin
        report_mismatch("result with no request", '0, got.rdata);
      end else begin
        exp_rsp = page_rsp_q.pop_front();
        if (got.rdata !== exp_rsp.rdata) report_mismatch("read_data", exp_rsp.rdata, got.rdata);
        if (got.pstat !== exp_rsp.pstat) begin
          report_mismatch("page_status", 32'(exp_rsp.pstat), 32'(got.pstat));
        end
        if (got.code !== exp_rsp.code) begin
          report_mismatch("result_code", 32'(exp_rsp.code), 32'(got.code));
        end
        if (m_tdata[OutDataWidth-1:37] !== '0) begin
          report_mismatch("pad bits", '0, 32'(m_tdata[39:37]));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic test_program_read();
    send_request(CMD_READ, 8'd0, 8'd0, 32'h0, 2'd0);
    send_request(CMD_GET, 8'd0, 8'd0, 32'h0, 2'd0);
    send_request(CMD_PROGRAM, 8'd0, 8'd0, 32'hFFFF_FFFF, 2'd3);
    send_request(CMD_PROGRAM, 8'd0, 8'd0, 32'h1234_5678, 2'd0);
    send_request(CMD_READ, 8'd0, 8'd0, 32'h0, 2'd0);
    send_request(CMD_PROGRAM, 8'd63, 8'd63, 32'h0, 2'd0);
    send_request(CMD_READ, 8'd63, 8'd63, 32'hFFFF_FFFF, 2'd3);
  endtask

  task automatic test_status_and_erase();
    send_request(CMD_SET, 8'd0, 8'd0, 32'h0, ST_INVALID);
    send_request(CMD_READ, 8'd0, 8'd0, 32'h0, 2'd0);
    send_request(CMD_SET, 8'd0, 8'd0, 32'h0, ST_VALID);
    // status code 3 is stored as invalid
    send_request(CMD_SET, 8'd0, 8'd1, 32'h0, 2'd3);
    send_request(CMD_GET, 8'd0, 8'd1, 32'h0, 2'd0);
    // erase ignores the page field
    send_request(CMD_ERASE, 8'd0, 8'd200, 32'hFFFF_FFFF, 2'd3);
    send_request(CMD_READ, 8'd0, 8'd1, 32'h0, 2'd0);
    send_request(CMD_GET, 8'd0, 8'd0, 32'h0, 2'd0);
    send_request(CMD_ERASE, 8'd63, 8'd0, 32'h0, 2'd0);
    send_request(CMD_READ, 8'd63, 8'd63, 32'h0, 2'd0);
  endtask

  task automatic test_bad_address_and_unknown();
    send_request(CMD_READ, 8'd64, 8'd0, 32'h0, 2'd0);
    send_request(CMD_PROGRAM, 8'd0, 8'd64, 32'hA5A5_A5A5, 2'd0);
    send_request(CMD_ERASE, 8'd255, 8'd0, 32'h0, 2'd0);
    send_request(CMD_GET, 8'd255, 8'd255, 32'h0, 2'd0);
    send_request(CMD_SET, 8'd64, 8'd64, 32'h0, ST_VALID);
    send_request(3'd5, 8'd1, 8'd1, 32'hFFFF_FFFF, 2'd1);
    send_request(3'd7, 8'd255, 8'd255, 32'hFFFF_FFFF, 2'd3);
  endtask

  task automatic test_random_traffic(input int unsigned count, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned sent;
    int unsigned pick;
    int unsigned where;
    logic [2:0]  cmd;
    logic [7:0]  blk;
    logic [7:0]  pg;
    src_idle_pct = idle_pct;
    snk_stall_pct = stall_pct;
    sent = 0;
    while (sent < count) begin
      if (sent >= count / 2 && sent < count / 2 + 2) wait_for_drain();
      where = $urandom_range(99);
      if (where < 75) begin
        blk = 8'($urandom_range(0, 3));
        pg = 8'($urandom_range(0, 7));
      end else if (where < 90) begin
        blk = 8'($urandom_range(0, NUM_BLOCKS - 1));
        pg = 8'($urandom_range(0, BLOCK_PAGES - 1));
      end else if ($urandom_range(1)) begin
        blk = 8'($urandom_range(NUM_BLOCKS, 255));
        pg = 8'($urandom_range(0, 255));
      end else begin
        blk = 8'($urandom_range(0, NUM_BLOCKS - 1));
        pg = 8'($urandom_range(BLOCK_PAGES, 255));
      end
      pick = $urandom_range(99);
      if (pick < 25) begin
        // program followed by a read back of the same page
        send_request(CMD_PROGRAM, blk, pg, $urandom, 2'($urandom_range(0, 3)));
        send_request(CMD_READ, blk, pg, $urandom, 2'($urandom_range(0, 3)));
        sent += 2;
      end else begin
        if (pick < 42) cmd = CMD_READ;
        else if (pick < 56) cmd = CMD_PROGRAM;
        else if (pick < 70) cmd = CMD_GET;
        else if (pick < 88) cmd = CMD_SET;
        else if (pick < 95) cmd = CMD_ERASE;
        else cmd = 3'($urandom_range(5, 7));
        send_request(cmd, blk, pg, $urandom, 2'($urandom_range(0, 3)));
        sent++;
      end
    end
  endtask

  initial begin
    for (int unsigned i = 0; i < PAGE_COUNT; i++) begin
      status_mem[SLOT_W'(i)] = ST_CLEAN;
      data_mem[SLOT_W'(i)] = '0;
      data_known[SLOT_W'(i)] = 1'b0;
    end
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_program_read();
    test_status_and_erase();
    test_bad_address_and_unknown();
    test_random_traffic(470, 0, 0);
    test_random_traffic(470, 84, 0);
    test_random_traffic(470, 0, 84);
    test_random_traffic(470, 19, 19);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
